FILE: rtl/cdct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deploy channel trigger package
// Shared widths, request codes, setting slots and controller/datapath types.
// ----------------------------------------------------------------------------
package cdct_pkg;

  localparam int unsigned MaxChannels = 8;
  localparam int unsigned ChW         = 3;
  localparam int unsigned SlotW       = 4;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 4;

  // Request codes.
  localparam logic [1:0] ReqEval   = 2'd0;
  localparam logic [1:0] ReqWrite  = 2'd1;
  localparam logic [1:0] ReqManual = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgBoost  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLanded = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOrient = 2'd2;

  // Setting slots.
  localparam logic [SlotW-1:0] SlotFlags   = 4'd0;
  localparam logic [SlotW-1:0] SlotAccLt   = 4'd1;
  localparam logic [SlotW-1:0] SlotAccGt   = 4'd2;
  localparam logic [SlotW-1:0] SlotSpdLt   = 4'd3;
  localparam logic [SlotW-1:0] SlotSpdGt   = 4'd4;
  localparam logic [SlotW-1:0] SlotHgtLt   = 4'd5;
  localparam logic [SlotW-1:0] SlotHgtGt   = 4'd6;
  localparam logic [SlotW-1:0] SlotOriLt   = 4'd7;
  localparam logic [SlotW-1:0] SlotOriGt   = 4'd8;
  localparam logic [SlotW-1:0] SlotTimLt   = 4'd9;
  localparam logic [SlotW-1:0] SlotTimGt   = 4'd10;
  localparam logic [SlotW-1:0] SlotStLt    = 4'd11;
  localparam logic [SlotW-1:0] SlotStGe    = 4'd12;
  localparam logic [SlotW-1:0] SlotMotor   = 4'd13;
  localparam logic [SlotW-1:0] SlotDelay   = 4'd14;
  localparam logic [SlotW-1:0] SlotInvalid = 4'd15;

  typedef struct packed {
    logic signed [15:0] accel;
    logic signed [15:0] speed;
    logic signed [15:0] height;
    logic [7:0]         orient;
    logic [3:0]         phase;
    logic [7:0]         motors_burnt;
    logic [15:0]        now_tick;
    logic [15:0]        boost_tick;
  } sample_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ChW-1:0]    channel;
    logic [SlotW-1:0]  setting_index;
    logic [15:0]       setting_value;
    sample_t           sample;
  } req_t;

  typedef struct packed {
    logic [7:0] fire_mask;
    logic [7:0] fired_mask;
    logic       armed_left;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic             load;      // capture request
    logic             rd_en;     // issue a settings read
    logic [ChW-1:0]   rd_ch;
    logic [SlotW-1:0] rd_slot;
    logic             cond_clr;  // start a channel's condition run
    logic             cond_chk;  // fold the slot that returned
    logic [SlotW-1:0] chk_slot;
    logic             decide;    // close the channel
    logic [ChW-1:0]   dec_ch;
    logic             apply;     // write / manual fire and build result
  } cmd_t;

  typedef struct packed {
    logic [1:0]   req_type;
    logic         in_window;
    logic         skip_ch;     // channel fired, disabled
  } sts_t;

endpackage

FILE: rtl/cdct_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deploy channel trigger stream interface
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface cdct_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/cdct_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deploy channel trigger datapath
// Settings memory, per-channel status, condition compare and result register.
// ----------------------------------------------------------------------------
module cdct_datapath
  import cdct_pkg::*;
#(
  parameter int unsigned NumChannels = MaxChannels
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  req_t                req_i,
  input  logic [3:0]          boost_state_i,
  input  logic [3:0]          landed_state_i,
  input  logic                orient_enable_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output rsp_t                rsp_o
);

  localparam int unsigned Depth = NumChannels * 16;
  localparam int unsigned AddrW = $clog2(Depth) < SlotW ? SlotW : $clog2(Depth);

  req_t               req_q;
  logic [15:0]        mem [Depth];
  logic [Depth-1:0]   vld_q;
  logic [15:0]        rd_q;
  logic [NumChannels-1:0] fired_q, pend_q, en_q, fire_q;
  logic [15:0]        dl_q [NumChannels];
  logic [15:0]        flags_q;
  logic               ok_q;
  rsp_t               rsp_q;
  logic [AddrW-1:0]   rd_addr, wr_addr;
  logic               ch_ok, wr_ok, mem_we;
  logic               hold, dir_ok;
  logic signed [15:0] lim, tval;
  logic [15:0]        dl_new, dl_use, dl_diff;
  logic               dl_reached, arm;
  logic [NumChannels-1:0] fire_all, fired_new;

  assign rd_addr = AddrW'({cmd_i.rd_ch, cmd_i.rd_slot});
  assign wr_addr = AddrW'({req_q.channel, req_q.setting_index});
  assign ch_ok   = 32'(req_q.channel) < NumChannels;
  assign wr_ok   = ch_ok && req_q.setting_index != SlotInvalid;
  assign mem_we  = cmd_i.apply && req_q.req_type == ReqWrite && wr_ok;

  // Settings memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= req_q.setting_value;
    end
    if (cmd_i.rd_en) begin
      rd_q <= vld_q[rd_addr] ? mem[rd_addr] : 16'd0;
    end
  end

  // Written marks, so that a slot never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  // Direction checks, taken from the flag word as it returns.
  assign dir_ok = (!rd_q[10] || req_q.sample.speed > 16'sd0) &&
                  (!rd_q[11] || req_q.sample.speed < 16'sd0);

  // Condition test for the slot just read.
  assign lim  = signed'(rd_q);
  assign tval = signed'(req_q.sample.now_tick - req_q.sample.boost_tick);
  always_comb begin
    hold = 1'b1;
    unique case (cmd_i.chk_slot)
      SlotAccLt: hold = !flags_q[0] || req_q.sample.accel <= lim;
      SlotAccGt: hold = !flags_q[1] || req_q.sample.accel >= lim;
      SlotSpdLt: hold = !flags_q[2] || req_q.sample.speed <= lim;
      SlotSpdGt: hold = !flags_q[3] || req_q.sample.speed >= lim;
      SlotHgtLt: hold = !flags_q[4] || req_q.sample.height <= lim;
      SlotHgtGt: hold = !flags_q[5] || req_q.sample.height >= lim;
      SlotOriLt: hold = !orient_enable_i || !flags_q[6] ||
                        signed'({8'd0, req_q.sample.orient}) <= lim;
      SlotOriGt: hold = !orient_enable_i || !flags_q[7] ||
                        signed'({8'd0, req_q.sample.orient}) >= lim;
      SlotTimLt: hold = !flags_q[8] || tval <= lim;
      SlotTimGt: hold = !flags_q[9] || tval >= lim;
      SlotStLt:  hold = !flags_q[14] || {4'd0, req_q.sample.phase} < rd_q[7:0];
      SlotStGe:  hold = !flags_q[15] || {4'd0, req_q.sample.phase} >= rd_q[7:0];
      SlotMotor: hold = !flags_q[12] || req_q.sample.motors_burnt == rd_q[7:0];
      default:   hold = 1'b1;
    endcase
  end

  // Deadline arithmetic for the channel being closed (delay is in rd_q).
  assign arm     = !pend_q[cmd_i.dec_ch] && ok_q && flags_q[13];
  assign dl_new  = (req_q.sample.now_tick + rd_q) == 16'd0 ? 16'd1
                 : req_q.sample.now_tick + rd_q;
  assign dl_use  = arm ? dl_new : dl_q[cmd_i.dec_ch];
  assign dl_diff = req_q.sample.now_tick - dl_use;
  assign dl_reached = !dl_diff[15];

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && arm) begin
      dl_q[cmd_i.dec_ch] <= dl_new;
    end
  end

  // Fired bits after this request: channels fired by evaluation set, a flag write clears, a manual fire sets.
  assign fire_all = fire_q;
  always_comb begin
    fired_new = fired_q | fire_all;
    if (req_q.req_type == ReqWrite && wr_ok && req_q.setting_index == SlotFlags) begin
      fired_new[req_q.channel] = 1'b0;
    end
    if (req_q.req_type == ReqManual && ch_ok) begin
      fired_new[req_q.channel] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fired_q <= '0;
      pend_q  <= '0;
      en_q    <= '0;
      fire_q  <= '0;
      flags_q <= '0;
      ok_q    <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        fire_q <= '0;
      end
      if (cmd_i.cond_clr) begin
        flags_q <= rd_q;
        ok_q    <= dir_ok;
      end else if (cmd_i.cond_chk) begin
        ok_q <= ok_q & hold;
      end
      // Close a channel: arm the delay and fire when due.
      if (cmd_i.decide) begin
        if (arm) begin
          pend_q[cmd_i.dec_ch] <= 1'b1;
        end
        if ((pend_q[cmd_i.dec_ch] || arm) ? dl_reached : ok_q) begin
          fire_q[cmd_i.dec_ch] <= 1'b1;
        end
      end
      if (cmd_i.apply) begin
        fired_q <= fired_new;
        if (req_q.req_type == ReqWrite && wr_ok && req_q.setting_index == SlotFlags) begin
          en_q[req_q.channel]    <= req_q.setting_value != 16'd0;
          pend_q[req_q.channel]  <= 1'b0;
        end
        if (req_q.req_type == ReqManual && ch_ok) begin
          fire_q[req_q.channel]  <= 1'b1;
        end
      end
    end
  end

  // Result register, loaded in the cycle after apply.
  logic apply_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apply_q <= 1'b0;
    end else begin
      apply_q <= cmd_i.apply;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_q) begin
      rsp_q.fire_mask  <= 8'(fire_q);
      rsp_q.fired_mask <= 8'(fired_q);
      rsp_q.armed_left <= |(en_q & ~fired_q);
    end
  end

  assign rsp_o = rsp_q;

  assign sts_o.req_type  = req_q.req_type;
  assign sts_o.in_window = req_q.sample.phase >= boost_state_i &&
                           req_q.sample.phase < landed_state_i;
  assign sts_o.skip_ch   = fired_q[cmd_i.dec_ch] || rd_q == 16'd0;

endmodule

FILE: rtl/cdct_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deploy channel trigger controller
// Sequences the channel sweep and the request handshakes.
// ----------------------------------------------------------------------------
module cdct_ctrl
  import cdct_pkg::*;
#(
  parameter int unsigned NumChannels = MaxChannels
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StStart = 3'd1;
  localparam logic [2:0] StFlags = 3'd2;
  localparam logic [2:0] StScan  = 3'd3;
  localparam logic [2:0] StApply = 3'd4;
  localparam logic [2:0] StBuild = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [ChW-1:0]   ch_q, ch_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic             last_ch;

  assign last_ch = 32'(ch_q) == NumChannels - 1;
  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = state_q == StOut;

  // Slots are read 1..14; the direction checks are taken from the flag word.
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    slot_d  = slot_q;
    cmd_o   = '0;
    cmd_o.rd_ch   = ch_q;
    cmd_o.dec_ch  = ch_q;
    cmd_o.rd_slot = slot_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          ch_d       = '0;
          state_d    = StStart;
        end
      end
      StStart: begin
        if (sts_i.req_type == ReqEval && sts_i.in_window) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_slot = SlotFlags;
          state_d       = StFlags;
        end else begin
          state_d = StApply;
        end
      end
      StFlags: begin
        if (sts_i.skip_ch) begin
          if (last_ch) begin
            state_d = StApply;
          end else begin
            ch_d          = ch_q + 1'b1;
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_ch   = ch_q + 1'b1;
            cmd_o.rd_slot = SlotFlags;
          end
        end else begin
          cmd_o.cond_clr = 1'b1;
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_slot  = SlotAccLt;
          slot_d         = SlotAccLt;
          state_d        = StScan;
        end
      end
      StScan: begin
        // The read data holds slot_q; the delay slot closes the channel.
        cmd_o.chk_slot = slot_q;
        cmd_o.cond_chk = 1'b1;
        if (slot_q == SlotMotor) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_slot = SlotDelay;
          slot_d        = SlotDelay;
        end else if (slot_q == SlotDelay) begin
          cmd_o.cond_chk = 1'b0;
          cmd_o.decide   = 1'b1;
          if (last_ch) begin
            state_d = StApply;
          end else begin
            ch_d          = ch_q + 1'b1;
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_ch   = ch_q + 1'b1;
            cmd_o.rd_slot = SlotFlags;
            state_d       = StFlags;
          end
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_slot = slot_q + 1'b1;
          slot_d        = slot_q + 1'b1;
        end
      end
      StApply: begin
        cmd_o.apply = 1'b1;
        state_d     = StBuild;
      end
      StBuild: begin
        state_d = StOut;
      end
      StOut: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ch_q    <= '0;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      slot_q  <= slot_d;
    end
  end

endmodule

FILE: rtl/conditional_deploy_channel_trigger_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deploy channel trigger core
// One request in, one status result out, per request.
// ----------------------------------------------------------------------------
// One request is handled at a time. Writes, manual fires, no-operation
// requests and evaluate requests outside the flight window skip the channel
// walk and go from acceptance straight through apply and build to a valid
// result. An evaluate request inside the window walks the channels through
// the single read port of the settings memory: only the flag word is read
// for a channel that is disabled or fired, and slots 0..14 for one that is
// tested. The result is held until it is taken, and a new request is
// accepted from the cycle after that.
module conditional_deploy_channel_trigger_core
  import cdct_pkg::*;
#(
  parameter int unsigned NumChannels = MaxChannels
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  cdct_if.sink                 req_if,
  cdct_if.source               rsp_if
);

  logic [3:0] boost_q, landed_q;
  logic       orient_q;
  cmd_t       cmd;
  sts_t       sts;
  rsp_t       rsp;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boost_q  <= 4'd3;
      landed_q <= 4'd8;
      orient_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBoost:  boost_q  <= cfg_data_i;
        CfgLanded: landed_q <= cfg_data_i;
        CfgOrient: orient_q <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  cdct_ctrl #(.NumChannels(NumChannels)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req_if.valid),
    .in_ready_o (req_if.ready),
    .out_valid_o(rsp_if.valid),
    .out_ready_i(rsp_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cdct_datapath #(.NumChannels(NumChannels)) u_dp (
    .clk_i, .rst_ni,
    .req_i          (req_if.data),
    .boost_state_i  (boost_q),
    .landed_state_i (landed_q),
    .orient_enable_i(orient_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .rsp_o          (rsp)
  );

  assign rsp_if.data = rsp;

endmodule
